/* hdl/phdf_pkg.sv */
// phdf_pkg: shared types for the pixel hit duplicate filter.
// Used by phdf_cell, phdf_chain and pixel_hit_duplicate_filter_top; no dependencies.
package phdf_pkg;

  localparam int unsigned KEY_W = 48;

  // Compare key: detector, chip, first and second address
  typedef logic [KEY_W-1:0] key_t;

  // Control broadcast from the scan controller to every cell
  typedef struct packed {
    logic start;    // load token into the first cell
    logic adv;      // token moves one cell this cycle
    logic kill;     // scan finishes this cycle, drop the token
    logic wr_slot;  // token sits on the first free cell, store key there
    logic cmp;      // token sits on a filled cell, compare is meaningful
  } chain_ctl_t;

endpackage

/* hdl/phdf_cell.sv */
// phdf_cell: one entry of the kept-hit store with its scan token stage.
// Depends on phdf_pkg.
module phdf_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  phdf_pkg::chain_ctl_t ctl,
  input  phdf_pkg::key_t      key_in,
  input  logic                tok_in,
  output logic                tok_out,
  output logic                hit
);
  import phdf_pkg::*;

  logic tok_r;
  logic tok_nxt;
  key_t key_r;

  // token hops to the next cell while scanning, dropped on finish
  always_comb begin
    tok_nxt = tok_r;
    if (ctl.start || ctl.adv) begin
      tok_nxt = tok_in & ~ctl.kill;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // stored key, written only when the token reaches the free slot
  always_ff @(posedge clk) begin
    if (tok_r && ctl.adv && ctl.wr_slot) begin
      key_r <= key_in;
    end
  end

  assign tok_out = tok_r;
  assign hit     = tok_r & ctl.cmp & (key_r == key_in);

endmodule

/* hdl/phdf_chain.sv */
// phdf_chain: row of phdf_cell entries forming the kept-hit store.
// Depends on phdf_pkg and phdf_cell.
module phdf_chain #(
  parameter int unsigned N = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  phdf_pkg::chain_ctl_t ctl,
  input  phdf_pkg::key_t      key,
  output logic                hit_any
);
  import phdf_pkg::*;

  logic [N:0]   tok;
  logic [N-1:0] hit;

  // cell 0 takes the token from the controller
  assign tok[0] = ctl.start;

  for (genvar i = 0; i < N; i++) begin : g_cell
    phdf_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .key_in  (key),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .hit     (hit[i])
    );
  end

  // only the cell holding the token can report a hit; tok[N] falls off the end
  assign hit_any = |hit | (tok[N] & 1'b0);

endmodule

/* hdl/pixel_hit_duplicate_filter_top.sv */
// Pixel hit duplicate filter. The result is registered when the scan token reaches the matching
// kept hit, or the end of the filled entries when none matches, after a request is accepted.
// One request at a time: new requests stall while a scan runs; the token walks the cell
// chain one entry per cycle, frozen while an older result is stalled.
// Reset (synchronous, rst_n low): fill count, duplicate flag, register and handshake clear;
// store contents stay undefined until written.
module pixel_hit_duplicate_filter_top #(
  parameter int unsigned MAX_HITS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_detector_id,
  input  logic [7:0]  in_chip_id,
  input  logic [15:0] in_first_address,
  input  logic [15:0] in_second_address,
  input  logic [15:0] in_hit_count,
  input  logic        in_last_of_event,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_detector_id,
  output logic [7:0]  out_chip_id,
  output logic [15:0] out_first_address,
  output logic [15:0] out_second_address,
  output logic [15:0] out_hit_count,
  output logic        out_is_duplicate,
  output logic        out_keep,
  output logic        out_any_duplicate,
  output logic        out_store_overflow,
  output logic        out_last
);
  import phdf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_HITS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_HITS);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic             dup_seen_r, dup_seen_nxt;
  logic             remove_r;
  logic             out_valid_r, out_valid_nxt;

  // held request
  key_t             key_r, key_nxt;
  logic [15:0]      count_r, count_nxt;
  logic             last_r, last_nxt;

  // result registers
  key_t             res_key_r, res_key_nxt;
  logic [15:0]      res_count_r, res_count_nxt;
  logic             res_dup_r, res_dup_nxt;
  logic             res_keep_r, res_keep_nxt;
  logic             res_any_r, res_any_nxt;
  logic             res_ovf_r, res_ovf_nxt;
  logic             res_last_r, res_last_nxt;

  chain_ctl_t       ctl;
  logic             hit_any;
  logic             in_acc;
  logic             out_free;
  logic             scan_end;
  logic             full;
  logic             finish;
  logic             dup;

  phdf_chain #(.N(MAX_HITS)) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .key     (key_r),
    .hit_any (hit_any)
  );

  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;
  assign scan_end = (idx_r == total_r);
  assign full     = (total_r == FULL);
  assign dup      = ~scan_end & hit_any;

  // chain control
  always_comb begin
    ctl.start   = in_acc;
    ctl.adv     = (state_r == ST_SCAN) & out_free;
    ctl.cmp     = ~scan_end;
    ctl.wr_slot = scan_end & ~full;
    finish      = ctl.adv & (scan_end | hit_any);
    ctl.kill    = finish;
  end

  // scan sequencing and result formation
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    dup_seen_nxt  = dup_seen_r;
    out_valid_nxt = out_valid_r & out_stall;
    key_nxt       = key_r;
    count_nxt     = count_r;
    last_nxt      = last_r;
    res_key_nxt   = res_key_r;
    res_count_nxt = res_count_r;
    res_dup_nxt   = res_dup_r;
    res_keep_nxt  = res_keep_r;
    res_any_nxt   = res_any_r;
    res_ovf_nxt   = res_ovf_r;
    res_last_nxt  = res_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt   = {in_detector_id, in_chip_id, in_first_address, in_second_address};
          count_nxt = in_hit_count;
          last_nxt  = in_last_of_event;
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ctl.adv) begin
          if (finish) begin
            out_valid_nxt = 1'b1;
            res_key_nxt   = key_r;
            res_count_nxt = count_r;
            res_dup_nxt   = dup;
            res_keep_nxt  = ~(remove_r & dup);
            res_any_nxt   = dup_seen_r | dup;
            res_ovf_nxt   = ~dup & full;
            res_last_nxt  = last_r;
            state_nxt     = ST_IDLE;
            if (last_r) begin
              total_nxt    = '0;
              dup_seen_nxt = 1'b0;
            end else begin
              dup_seen_nxt = dup_seen_r | dup;
              if (!dup && !full) begin
                total_nxt = total_r + 1'b1;
              end
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      total_r     <= '0;
      dup_seen_r  <= 1'b0;
      remove_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      total_r     <= total_nxt;
      dup_seen_r  <= dup_seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        remove_r <= cfg_wr_data;
      end
    end
    key_r       <= key_nxt;
    count_r     <= count_nxt;
    last_r      <= last_nxt;
    res_key_r   <= res_key_nxt;
    res_count_r <= res_count_nxt;
    res_dup_r   <= res_dup_nxt;
    res_keep_r  <= res_keep_nxt;
    res_any_r   <= res_any_nxt;
    res_ovf_r   <= res_ovf_nxt;
    res_last_r  <= res_last_nxt;
  end

  // ports
  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_detector_id    = res_key_r[47:40];
  assign out_chip_id        = res_key_r[39:32];
  assign out_first_address  = res_key_r[31:16];
  assign out_second_address = res_key_r[15:0];
  assign out_hit_count      = res_count_r;
  assign out_is_duplicate   = res_dup_r;
  assign out_keep           = res_keep_r;
  assign out_any_duplicate  = res_any_r;
  assign out_store_overflow = res_ovf_r;
  assign out_last           = res_last_r;

endmodule

/* dv/pixel_hit_duplicate_filter_top_tb.sv */
// Testbench for pixel_hit_duplicate_filter_top: directed and random events with random idling.
// A scoreboard class predicts each result in the testbench and checks every field of every result.
// Depends on phdf_pkg (key_t, KEY_W) and the filter RTL.
`timescale 1ns / 100ps

module pixel_hit_duplicate_filter_top_tb;
  import phdf_pkg::*;

  localparam int unsigned STORE_DEPTH     = 256;
  localparam int unsigned QUIET_LIMIT     = 10 * (STORE_DEPTH + 30);
  localparam int unsigned DRAIN_CYCLES    = STORE_DEPTH + 8;
  localparam int unsigned ITEMS_PER_PHASE = 290;
  localparam int unsigned MAX_IDLE        = 12;

  typedef struct packed {
    logic [7:0]  detector_id;
    logic [7:0]  chip_id;
    logic [15:0] first_address;
    logic [15:0] second_address;
    logic [15:0] hit_count;
    logic        last_of_event;
  } pixel_hit_t;

  typedef struct packed {
    logic [7:0]  detector_id;
    logic [7:0]  chip_id;
    logic [15:0] first_address;
    logic [15:0] second_address;
    logic [15:0] hit_count;
    logic        is_duplicate;
    logic        keep;
    logic        any_duplicate;
    logic        store_overflow;
    logic        last;
  } hit_verdict_t;

  // Tracks kept keys per event and the verdicts still owed by the block
  class dup_filter_scoreboard;
    key_t         kept_keys[$];
    bit           dup_seen;
    bit           drop_dups;
    hit_verdict_t owed_verdicts[$];
    int unsigned  errors;
    int unsigned  results_seen;

    function void set_removal(bit on);
      drop_dups = on;
    endfunction

    function int unsigned pending();
      return owed_verdicts.size();
    endfunction

    task report(string msg);
      if (errors < 40) $display("[%0t] ERROR %s", $time, msg);
      errors++;
    endtask

    // work out the verdict for one accepted request and update event state
    function void note_request(pixel_hit_t h);
      key_t         k;
      hit_verdict_t v;
      bit           dup;
      k   = {h.detector_id, h.chip_id, h.first_address, h.second_address};
      dup = 1'b0;
      foreach (kept_keys[i])
        if (kept_keys[i] == k) dup = 1'b1;
      v.store_overflow = 1'b0;
      if (dup) begin
        dup_seen = 1'b1;
      end else if (kept_keys.size() < STORE_DEPTH) begin
        kept_keys.insert(kept_keys.size(), k);
      end else begin
        v.store_overflow = 1'b1;
      end
      v.detector_id    = h.detector_id;
      v.chip_id        = h.chip_id;
      v.first_address  = h.first_address;
      v.second_address = h.second_address;
      v.hit_count      = h.hit_count;
      v.is_duplicate   = dup;
      v.keep           = !(drop_dups && dup);
      v.any_duplicate  = dup_seen;
      v.last           = h.last_of_event;
      owed_verdicts.insert(owed_verdicts.size(), v);
      // event end clears store and sticky flag
      if (h.last_of_event) begin
        kept_keys.delete();
        dup_seen = 1'b0;
      end
    endfunction

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %h want %h", results_seen, name, got, want));
    endtask

    task check_result(hit_verdict_t got);
      hit_verdict_t want;
      if (owed_verdicts.size() == 0) begin
        report($sformatf("result %0d arrived with no request pending", results_seen));
        results_seen++;
        return;
      end
      want = owed_verdicts.pop_front();
      compare_field("detector_id", 16'(got.detector_id), 16'(want.detector_id));
      compare_field("chip_id", 16'(got.chip_id), 16'(want.chip_id));
      compare_field("first_address", got.first_address, want.first_address);
      compare_field("second_address", got.second_address, want.second_address);
      compare_field("hit_count", got.hit_count, want.hit_count);
      compare_field("is_duplicate", 16'(got.is_duplicate), 16'(want.is_duplicate));
      compare_field("keep", 16'(got.keep), 16'(want.keep));
      compare_field("any_duplicate", 16'(got.any_duplicate), 16'(want.any_duplicate));
      compare_field("store_overflow", 16'(got.store_overflow), 16'(want.store_overflow));
      compare_field("last", 16'(got.last), 16'(want.last));
      results_seen++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  pixel_hit_t  in_hit;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_detector_id;
  logic [7:0]  out_chip_id;
  logic [15:0] out_first_address;
  logic [15:0] out_second_address;
  logic [15:0] out_hit_count;
  logic        out_is_duplicate;
  logic        out_keep;
  logic        out_any_duplicate;
  logic        out_store_overflow;
  logic        out_last;

  bit          in_idle_on;
  bit          out_idle_on;
  int unsigned items_sent;
  pixel_hit_t  carry_hits[$];

  dup_filter_scoreboard sb = new();

  always #1 clk = ~clk;

  pixel_hit_duplicate_filter_top #(
    .MAX_HITS(STORE_DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_detector_id    (in_hit.detector_id),
    .in_chip_id        (in_hit.chip_id),
    .in_first_address  (in_hit.first_address),
    .in_second_address (in_hit.second_address),
    .in_hit_count      (in_hit.hit_count),
    .in_last_of_event  (in_hit.last_of_event),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_detector_id   (out_detector_id),
    .out_chip_id       (out_chip_id),
    .out_first_address (out_first_address),
    .out_second_address(out_second_address),
    .out_hit_count     (out_hit_count),
    .out_is_duplicate  (out_is_duplicate),
    .out_keep          (out_keep),
    .out_any_duplicate (out_any_duplicate),
    .out_store_overflow(out_store_overflow),
    .out_last          (out_last)
  );

  function automatic pixel_hit_t make_hit(logic [7:0] det, logic [7:0] chip,
                                          logic [15:0] a1, logic [15:0] a2,
                                          logic [15:0] cnt, logic last);
    return '{det, chip, a1, a2, cnt, last};
  endfunction

  function automatic pixel_hit_t random_hit();
    return '{8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0};
  endfunction

  // present one request after a random gap, return at the edge that takes it
  task automatic send_hit(pixel_hit_t h);
    int unsigned gap;
    gap = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_hit   = h;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_request(h);
    items_sent++;
  endtask

  // hold off the sender until every owed result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_removal(bit on);
    wait_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = on;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_removal(on);
  endtask

  // one event: repeats of earlier hits with fresh counts, near misses, keys of the last event
  task automatic run_event(int unsigned len, int unsigned dup_pct);
    pixel_hit_t  sent[$];
    pixel_hit_t  h;
    key_t        k;
    int unsigned flip;
    for (int unsigned n = 0; n < len; n++) begin
      if (sent.size() != 0 && $urandom_range(0, 99) < dup_pct) begin
        h           = sent[$urandom_range(0, sent.size() - 1)];
        h.hit_count = 16'($urandom);
        // near miss: one key bit flipped
        if ($urandom_range(0, 5) == 0) begin
          flip = $urandom_range(0, KEY_W - 1);
          k    = {h.detector_id, h.chip_id, h.first_address, h.second_address};
          k    = k ^ (key_t'(1) << flip);
          {h.detector_id, h.chip_id, h.first_address, h.second_address} = k;
        end
      end else if (carry_hits.size() != 0 && $urandom_range(0, 9) == 0) begin
        h = carry_hits[$urandom_range(0, carry_hits.size() - 1)];
      end else begin
        h = random_hit();
      end
      h.last_of_event = (n == len - 1);
      if ($urandom_range(0, 49) == 0) wait_drained();
      send_hit(h);
      sent.insert(sent.size(), h);
    end
    carry_hits = sent;
  endtask

  // result side: check each accepted result, then stall at random while output idling is on
  initial begin : result_side
    int unsigned  hold;
    hit_verdict_t got;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        got = '{out_detector_id, out_chip_id, out_first_address, out_second_address,
                out_hit_count, out_is_duplicate, out_keep, out_any_duplicate,
                out_store_overflow, out_last};
        sb.check_result(got);
        hold = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      @(negedge clk);
      if (hold != 0) begin
        out_stall = 1'b1;
        hold--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // watchdog on cycles with no request or result moving
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0) || rst_n !== 1'b1)
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("pixel_hit_duplicate_filter_top: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_start;
    bit          big_done;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid    = 1'b0;
    in_hit      = '0;
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    items_sent  = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed: marking only
    write_removal(1'b0);
    send_hit(make_hit(8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_hit(make_hit(8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff, 1'b0));
    send_hit(make_hit(8'h00, 8'h00, 16'h0000, 16'h0000, 16'hffff, 1'b0));
    send_hit(make_hit(8'hff, 8'hff, 16'hffff, 16'hffff, 16'h0000, 1'b0));
    send_hit(make_hit(8'h01, 8'h00, 16'h0000, 16'h0000, 16'h1234, 1'b0));
    send_hit(make_hit(8'h00, 8'h01, 16'h0000, 16'h0000, 16'h1234, 1'b0));
    send_hit(make_hit(8'h00, 8'h00, 16'h0001, 16'h0000, 16'h1234, 1'b0));
    send_hit(make_hit(8'h00, 8'h00, 16'h0000, 16'h0001, 16'h1234, 1'b0));
    send_hit(make_hit(8'h00, 8'h00, 16'h0000, 16'h0001, 16'h8000, 1'b1));
    // store cleared: same key opens the next event as unique
    send_hit(make_hit(8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0001, 1'b1));
    send_hit(make_hit(8'hff, 8'hff, 16'hffff, 16'hffff, 16'h0002, 1'b0));
    send_hit(make_hit(8'hff, 8'hff, 16'hffff, 16'hffff, 16'h0003, 1'b1));

    // directed: removal on
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    write_removal(1'b1);
    send_hit(make_hit(8'h5a, 8'ha5, 16'h5a5a, 16'ha5a5, 16'h0010, 1'b0));
    send_hit(make_hit(8'h5a, 8'ha5, 16'h5a5a, 16'ha5a5, 16'h0011, 1'b0));
    send_hit(make_hit(8'ha5, 8'h5a, 16'ha5a5, 16'h5a5a, 16'h0012, 1'b0));
    send_hit(make_hit(8'h5a, 8'ha5, 16'h5a5a, 16'ha5a5, 16'h0013, 1'b0));
    send_hit(make_hit(8'ha5, 8'h5a, 16'ha5a5, 16'h5a5a, 16'h0014, 1'b1));

    // random phases, alternating the removal setting; later phases fill the store past full
    for (int p = 0; p < 4; p++) begin
      write_removal(bit'(p % 2));
      phase_start = items_sent;
      big_done    = (p < 2);
      while (items_sent - phase_start < ITEMS_PER_PHASE) begin
        in_idle_on  = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
        if (!big_done) begin
          run_event(STORE_DEPTH + 40, 6);
          big_done = 1'b1;
        end else begin
          run_event($urandom_range(1, 24), $urandom_range(0, 70));
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0)
      $display("pixel_hit_duplicate_filter_top: match");
    else
      $display("pixel_hit_duplicate_filter_top: mismatch");
    $finish;
  end

endmodule
